>>> sv/blm_pkg.sv
package blm_pkg;

    localparam int NUM_BANDS = 16;
    localparam int CNT_W     = $clog2(NUM_BANDS);

    localparam int MAG_SHIFT = 11;
    localparam int MAG_W     = 5;
    localparam int BASS_EDGE = 5;
    localparam int MID_EDGE  = 11;

    localparam logic [3:0] DECAY_RESET = 4'd2;
    localparam logic [7:0] MAXH_RESET  = 8'd64;

    typedef enum logic {
        CFG_DECAY_RATE = 1'b0,
        CFG_MAX_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [4:0] band_index;
        logic [8:0] height;
        logic       last_band;
    } t_out_item;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic             sample_en;
        logic             tick_en;
        logic             shift_en;
        logic [MAG_W-1:0] mag;
        logic [3:0]       decay;
    } t_cell_ctrl;

    // Height of one band for a scaled magnitude
    function automatic logic [8:0] band_weight(input logic [4:0] band,
                                               input logic [MAG_W-1:0] mag);
        logic [8:0] mag9;
        logic [8:0] h;
        mag9 = {{(9 - MAG_W){1'b0}}, mag};
        if (band < 5'(BASS_EDGE)) begin
            h = 9'((mag9 * (9'(BASS_EDGE) - {4'b0, band})) >> 2);
        end else if (band < 5'(MID_EDGE)) begin
            h = mag9 >> 1;
        end else begin
            h = mag9 >> 2;
        end
        return h + {7'b0, band[1:0]};
    endfunction

endpackage

>>> sv/band_level_meter_peak_decay.sv
// Sample transaction: on acceptance the scaled magnitude is registered, and the targets
//   update in the cycle after; the input stalls for that cycle.
// Tick transaction: all bands update together on acceptance, then NUM_BANDS results leave
//   one per cycle through the cell chain while the sink does not stall; the first result
//   is valid in the cycle after acceptance, and the input stalls until the last has left.
// Reset (synchronous, active low) clears heights and targets, decay_rate 2, max_height 64.
module band_level_meter_peak_decay (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  blm_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output blm_pkg::t_out_item  o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    localparam int N = blm_pkg::NUM_BANDS;
    localparam int W = blm_pkg::MAG_W;

    logic [3:0]                r_decay;
    logic [7:0]                r_maxh;
    logic [W-1:0]              r_mag;
    logic                      r_mag_vld;
    logic                      r_emit;
    logic [blm_pkg::CNT_W-1:0] r_cnt;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic [16:0]               w_abs;
    logic [W-1:0]              w_mag;
    blm_pkg::t_cell_ctrl       w_ctrl;
    logic [8:0]                w_chain [N+1];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_mag_vld | r_emit;
    assign w_in_acc    = i_valid & ~o_stall;
    assign w_out_acc   = r_emit & ~i_stall;

    // magnitude of the sample, scaled and capped
    always_comb begin
        w_abs = i_item.sample[15] ? (17'h10000 - {1'b0, i_item.sample})
                                  : {1'b0, i_item.sample};
        w_mag = W'(w_abs >> blm_pkg::MAG_SHIFT);
        if ({3'b0, w_mag} > r_maxh) begin
            w_mag = r_maxh[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= blm_pkg::DECAY_RESET;
            r_maxh  <= blm_pkg::MAXH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (blm_pkg::t_cfg_index'(i_cfg_index))
                blm_pkg::CFG_DECAY_RATE: r_decay <= i_cfg_data[3:0];
                blm_pkg::CFG_MAX_HEIGHT: r_maxh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_vld <= 1'b0;
            r_emit    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_mag_vld <= w_in_acc && (i_item.operation == blm_pkg::OP_SAMPLE);
            if (w_in_acc && (i_item.operation == blm_pkg::OP_TICK)) begin
                r_emit <= 1'b1;
                r_cnt  <= '0;
            end else if (w_out_acc) begin
                if (r_cnt == blm_pkg::CNT_W'(N - 1)) begin
                    r_emit <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + blm_pkg::CNT_W'(1);
                end
            end
        end
        if (w_in_acc) begin
            r_mag <= w_mag;
        end
    end

    assign w_ctrl.sample_en = r_mag_vld;
    assign w_ctrl.tick_en   = w_in_acc && (i_item.operation == blm_pkg::OP_TICK);
    assign w_ctrl.shift_en  = w_out_acc;
    assign w_ctrl.mag       = r_mag;
    assign w_ctrl.decay     = r_decay;

    assign w_chain[N] = 9'd0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        blm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_band     (5'(g)),
            .i_next_out (w_chain[g+1]),
            .o_out      (w_chain[g])
        );
    end

    assign o_valid          = r_emit;
    assign o_res.band_index = 5'(r_cnt);
    assign o_res.height     = w_chain[0];
    assign o_res.last_band  = (r_cnt == blm_pkg::CNT_W'(N - 1));

endmodule

>>> sv/blm_cell.sv
module blm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  blm_pkg::t_cell_ctrl i_ctrl,
    input  logic [4:0]          i_band,
    input  logic [8:0]          i_next_out,
    output logic [8:0]          o_out
);

    logic [8:0] r_shown;
    logic [8:0] r_target;
    logic [8:0] r_out;
    logic [8:0] n_shown;
    logic [8:0] n_target;
    logic [8:0] n_out;
    logic [8:0] w_weight;
    logic [8:0] w_decay;

    assign w_weight = blm_pkg::band_weight(i_band, i_ctrl.mag);
    assign w_decay  = {5'b0, i_ctrl.decay};

    always_comb begin
        n_shown  = r_shown;
        n_target = r_target;
        n_out    = r_out;
        if (i_ctrl.sample_en) begin
            if (w_weight > r_target) begin
                n_target = w_weight;
            end
        end else if (i_ctrl.tick_en) begin
            if (r_shown < r_target) begin
                n_shown = r_target;
            end else if (r_shown > r_target) begin
                n_shown = (r_shown > w_decay) ? (r_shown - w_decay) : 9'd0;
            end
            if (r_target != 9'd0) begin
                n_target = r_target - 9'd1;
            end
            n_out = n_shown;
        end else if (i_ctrl.shift_en) begin
            // advance the report chain towards band 0
            n_out = i_next_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown  <= '0;
            r_target <= '0;
        end else begin
            r_shown  <= n_shown;
            r_target <= n_target;
        end
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

>>> sv/blm_checker.sv
module blm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input blm_pkg::t_out_item o_res
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // no new transaction while a tick is still reporting
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during report");

    // bands advance by one within a run
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_res.last_band |=>
            o_valid && (o_res.band_index == $past(o_res.band_index) + 5'd1))
        else $error("band order broken");

    // the run ends after the last band
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_res.last_band |=> !o_valid)
        else $error("result after last band");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last_band |->
            (o_res.band_index == 5'(blm_pkg::NUM_BANDS - 1)))
        else $error("last band flag misplaced");

endmodule

bind band_level_meter_peak_decay blm_checker u_blm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

>>> test/band_level_checker.sv
module band_level_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  blm_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  blm_pkg::t_out_item i_out_res,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [8:0]         bar_height [blm_pkg::NUM_BANDS];
    logic [8:0]         bar_target [blm_pkg::NUM_BANDS];
    logic [3:0]         cur_decay;
    logic [7:0]         cur_cap;
    blm_pkg::t_out_item heights_due [$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic clear_meter();
        cur_decay = blm_pkg::DECAY_RESET;
        cur_cap   = blm_pkg::MAXH_RESET;
        for (int b = 0; b < blm_pkg::NUM_BANDS; b++) begin
            bar_height[b] = '0;
            bar_target[b] = '0;
        end
        heights_due.delete();
    endtask

    // Raise each band's target to the weighted level of this sample
    task automatic absorb_sample(input logic [15:0] smp);
        logic [16:0] mag17;
        int          mag;
        int          lvl;
        if (smp[15]) begin
            mag17 = 17'h10000 - {1'b0, smp};
        end else begin
            mag17 = {1'b0, smp};
        end
        mag = int'(mag17 >> blm_pkg::MAG_SHIFT);
        if (mag > int'(cur_cap)) begin
            mag = int'(cur_cap);
        end
        for (int b = 0; b < blm_pkg::NUM_BANDS; b++) begin
            if (b < blm_pkg::BASS_EDGE) begin
                lvl = (mag * (blm_pkg::BASS_EDGE - b)) >> 2;
            end else if (b < blm_pkg::MID_EDGE) begin
                lvl = mag >> 1;
            end else begin
                lvl = mag >> 2;
            end
            lvl = (lvl + (b & 3)) & 9'h1FF;
            if (lvl > int'(bar_target[b])) begin
                bar_target[b] = 9'(lvl);
            end
        end
    endtask

    // Move every bar toward its target and queue the heights it will show
    task automatic advance_bars();
        logic [8:0]         cur;
        logic [8:0]         tgt;
        blm_pkg::t_out_item row;
        for (int b = 0; b < blm_pkg::NUM_BANDS; b++) begin
            cur = bar_height[b];
            tgt = bar_target[b];
            if (cur < tgt) begin
                cur = tgt;
            end else if (cur > tgt) begin
                cur = (cur > {5'b0, cur_decay}) ? cur - {5'b0, cur_decay} : 9'd0;
            end
            bar_height[b] = cur;
            if (tgt != 0) begin
                bar_target[b] = tgt - 9'd1;
            end
            row.band_index = 5'(b);
            row.height     = cur;
            row.last_band  = (b == blm_pkg::NUM_BANDS - 1);
            heights_due.push_back(row);
        end
    endtask

    always @(posedge i_clk) begin
        blm_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_meter();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    blm_pkg::CFG_DECAY_RATE: cur_decay = i_cfg_data[3:0];
                    blm_pkg::CFG_MAX_HEIGHT: cur_cap   = i_cfg_data;
                    default: ;
                endcase
            end
            // results leaving now belong to earlier ticks, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                if (heights_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result band %0d height %0d last %0b",
                             $time, i_out_res.band_index, i_out_res.height,
                             i_out_res.last_band);
                end else begin
                    want = heights_due.pop_front();
                    if (want.band_index !== i_out_res.band_index
                        || want.height !== i_out_res.height
                        || want.last_band !== i_out_res.last_band) begin
                        fail_total++;
                        $display({"%0t: mismatch expected band %0d height %0d last %0b,",
                                  " got band %0d height %0d last %0b"},
                                 $time, want.band_index, want.height, want.last_band,
                                 i_out_res.band_index, i_out_res.height,
                                 i_out_res.last_band);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.operation == blm_pkg::OP_TICK) begin
                    advance_bars();
                end else begin
                    absorb_sample(i_in_item.sample);
                end
            end
        end
        o_pending <= heights_due.size();
    end

endmodule

>>> test/tb_band_level_meter_peak_decay.sv
module tb_band_level_meter_peak_decay;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               dut_stall;
    blm_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    blm_pkg::t_out_item out_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data  = 8'd0;

    int fails;
    int pending;
    bit no_gaps   = 1'b0;
    bit sink_free = 1'b0;
    int stall_left = 0;
    int pace_r;

    band_level_meter_peak_decay u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (dut_stall),
        .i_item      (in_item),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_res       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    band_level_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (dut_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_res    (out_res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sink back-pressure: runs of stall and free cycles, now and then a long hold
    always @(posedge clk) begin
        if (sink_free) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            pace_r = $urandom_range(0, 99);
            if (pace_r < 65) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 5);
            end else if (pace_r < 95) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input blm_pkg::t_op op, input logic [15:0] smp);
        blm_pkg::t_in_item it;
        int                gap;
        it.operation = op;
        it.sample    = smp;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (dut_stall);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_item  <= 17'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input blm_pkg::t_cfg_index idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every queued height has left, then let the block settle
    task automatic drain_meter();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (blm_pkg::NUM_BANDS + 4) @(posedge clk);
    endtask

    task automatic random_item();
        int          r;
        logic [15:0] smp;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            send_item(blm_pkg::OP_TICK, 16'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                smp = 16'($urandom);
            end else if (r < 75) begin
                case ($urandom_range(0, 3))
                    0: smp = 16'h7FFF;
                    1: smp = 16'h8000;
                    2: smp = 16'h0000;
                    default: smp = 16'hFFFF;
                endcase
            end else begin
                smp = 16'($urandom_range(0, 8191));
                if ($urandom_range(0, 1)) smp = -smp;
            end
            send_item(blm_pkg::OP_SAMPLE, smp);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes of the sample and ticks with empty targets
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_SAMPLE, 16'h7FFF);
        send_item(blm_pkg::OP_SAMPLE, 16'h8000);
        send_item(blm_pkg::OP_TICK, 16'hFFFF);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_SAMPLE, 16'h0000);
        send_item(blm_pkg::OP_SAMPLE, 16'hFFFF);
        send_item(blm_pkg::OP_SAMPLE, 16'h07FF);
        send_item(blm_pkg::OP_SAMPLE, 16'h0800);
        send_item(blm_pkg::OP_TICK, 16'h1234);
        send_item(blm_pkg::OP_SAMPLE, 16'h8001);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        drain_meter();

        // no decay: bars hold above a falling target
        write_reg(blm_pkg::CFG_DECAY_RATE, 8'd0);
        write_reg(blm_pkg::CFG_MAX_HEIGHT, 8'd255);
        send_item(blm_pkg::OP_SAMPLE, 16'h7FFF);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        drain_meter();

        // heavy decay: bars stop at zero
        write_reg(blm_pkg::CFG_DECAY_RATE, 8'd15);
        write_reg(blm_pkg::CFG_MAX_HEIGHT, 8'd0);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_SAMPLE, 16'h8000);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        send_item(blm_pkg::OP_TICK, 16'h0000);
        drain_meter();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(blm_pkg::CFG_DECAY_RATE, 8'd15);
                    write_reg(blm_pkg::CFG_MAX_HEIGHT, 8'd255);
                end
                1: begin
                    write_reg(blm_pkg::CFG_DECAY_RATE, 8'd0);
                    write_reg(blm_pkg::CFG_MAX_HEIGHT, 8'd1);
                end
                default: begin
                    write_reg(blm_pkg::CFG_DECAY_RATE, 8'($urandom));
                    write_reg(blm_pkg::CFG_MAX_HEIGHT,
                              $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                        : 8'($urandom_range(0, 20)));
                end
            endcase
            no_gaps   = (phase == 2);
            sink_free = (phase == 3);
            for (int n = 0; n < 75; n++) begin
                if (n == 40) begin
                    drain_meter();
                    no_gaps   = 1'b0;
                    sink_free = 1'b0;
                end
                random_item();
            end
            drain_meter();
        end

        if (fails == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
